@@ rtl/core/mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the mean cosine distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  // Component width of one ray coordinate, signed Q3.12.
  localparam int unsigned CompW = 16;
  // Default limit of pairs in one set.
  localparam int unsigned MaxPairsDef = 4096;
  // One in Q1.14.
  localparam logic [15:0] OneQ14 = 16'd16384;
  // Width of the shared divider's dividend register.
  localparam int unsigned DivNumW = 48;
  // Steps of the square root and of the per-pair quotient.
  localparam int unsigned RootSteps = 32;
  localparam int unsigned QuotSteps = 16;

  typedef struct packed {
    logic signed [CompW-1:0] first_x;
    logic signed [CompW-1:0] first_y;
    logic signed [CompW-1:0] first_z;
    logic signed [CompW-1:0] second_x;
    logic signed [CompW-1:0] second_y;
    logic signed [CompW-1:0] second_z;
    logic                    pair_present;
    logic                    end_of_set;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] mean_distance;
    logic [12:0] pair_count;
    logic        degenerate;
  } out_beat_t;

  typedef enum logic [3:0] {
    StIdle,
    StProd,
    StNorm,
    StRoot,
    StQInit,
    StQStep,
    StAccum,
    StMInit,
    StMStep,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       prod;
    logic [1:0] idx;
    logic       norm;
    logic       root;
    logic       qinit;
    logic       step;
    logic       accum;
    logic       minit;
    logic       done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pair_ok;
    logic last;
    logic zero_norm;
    logic cnt_zero;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcd_ctrl
// Sequencer of the mean cosine distance core: steps the datapath through
// products, square root, quotient, accumulation and the final mean.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_ctrl #(
  parameter int unsigned MeanSteps = 28
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  mcd_pkg::sts_t     sts_i,
  output mcd_pkg::cmd_t     cmd_o
);

  mcd_pkg::state_e state_q, state_d;
  logic [5:0]      cnt_q, cnt_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcd_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q[1:0];
    in_stall_o = 1'b1;
    unique case (state_q)
      mcd_pkg::StIdle: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
        end
      end
      mcd_pkg::StProd: begin
        cmd_o.prod = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'd2) begin
          state_d = mcd_pkg::StNorm;
        end
      end
      mcd_pkg::StNorm: begin
        cmd_o.norm = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.zero_norm ? mcd_pkg::StAccum : mcd_pkg::StRoot;
      end
      mcd_pkg::StRoot: begin
        cmd_o.root = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'(mcd_pkg::RootSteps - 1)) begin
          state_d = mcd_pkg::StQInit;
        end
      end
      mcd_pkg::StQInit: begin
        cmd_o.qinit = 1'b1;
        cnt_d       = '0;
        state_d     = mcd_pkg::StQStep;
      end
      mcd_pkg::StQStep: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'(mcd_pkg::QuotSteps - 1)) begin
          state_d = mcd_pkg::StAccum;
        end
      end
      mcd_pkg::StAccum: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.last ? mcd_pkg::StMInit : mcd_pkg::StIdle;
      end
      mcd_pkg::StMInit: begin
        cmd_o.minit = 1'b1;
        cnt_d       = '0;
        state_d     = sts_i.cnt_zero ? mcd_pkg::StDone : mcd_pkg::StMStep;
      end
      mcd_pkg::StMStep: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'(MeanSteps - 1)) begin
          state_d = mcd_pkg::StDone;
        end
      end
      mcd_pkg::StDone: begin
        if (!sts_i.out_busy) begin
          cmd_o.done = 1'b1;
          state_d    = mcd_pkg::StIdle;
        end
      end
      default: state_d = mcd_pkg::StIdle;
    endcase

    // Routing of an accepted beat.
    if (cmd_o.load) begin
      if (sts_i.pair_ok) begin
        state_d = mcd_pkg::StProd;
      end else if (sts_i.last) begin
        state_d = mcd_pkg::StMInit;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcd_dpath.sv @@
// ----------------------------------------------------------------------------
// mcd_dpath
// Datapath of the mean cosine distance core: products, bitwise square root,
// shared restoring divider, running sum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_dpath #(
  parameter int unsigned MaxPairs = mcd_pkg::MaxPairsDef,
  parameter int unsigned CntW     = 13,
  parameter int unsigned SumW     = 28
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mcd_pkg::in_beat_t    in_i,
  input  mcd_pkg::cmd_t        cmd_i,
  output mcd_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output mcd_pkg::out_beat_t   out_o
);

  localparam int unsigned NW = mcd_pkg::DivNumW;
  localparam int unsigned CW = mcd_pkg::CompW;

  logic signed [CW-1:0] a_q [3];
  logic signed [CW-1:0] b_q [3];
  logic                 pair_q, last_q;
  logic [31:0]          n1_q, n2_q;
  logic signed [33:0]   dot_q;
  logic [32:0]          mag_q;
  logic                 neg_q, degen_q;
  logic [63:0]          x_q, res_q, bit_q;
  logic [NW-1:0]        num_q;
  logic [31:0]          rem_q, den_q;
  logic [SumW-1:0]      sum_q;
  logic [CntW-1:0]      pcnt_q;
  logic                 flag_q;
  logic                 out_valid_q;
  mcd_pkg::out_beat_t   out_q;

  // Per-component products.
  logic signed [CW-1:0]   a_sel, b_sel;
  logic signed [2*CW-1:0] p_aa, p_bb, p_ab;
  always_comb begin
    a_sel = a_q[cmd_i.idx];
    b_sel = b_q[cmd_i.idx];
    p_aa  = a_sel * a_sel;
    p_bb  = b_sel * b_sel;
    p_ab  = a_sel * b_sel;
  end

  // One square root step.
  logic [63:0] trial;
  assign trial = res_q + bit_q;

  // One restoring divide step.
  logic [32:0] rem_sh, rem_sub;
  logic        qbit;
  always_comb begin
    rem_sh  = {rem_q, num_q[NW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = (rem_sh >= {1'b0, den_q});
  end

  // Per-pair dividend and the mean dividend.
  logic [NW-1:0]   pnum;
  logic [SumW:0]   mnum;
  always_comb begin
    pnum = (NW'(mag_q) << 14) + NW'(res_q[32:1]);
    mnum = (SumW+1)'(sum_q) + (SumW+1)'(pcnt_q >> 1);
  end

  // Term of a finished pair.
  logic [15:0] qv, qc, term;
  always_comb begin
    qv = num_q[15:0];
    qc = (qv > mcd_pkg::OneQ14) ? mcd_pkg::OneQ14 : qv;
    if (degen_q) begin
      term = mcd_pkg::OneQ14;
    end else if (neg_q) begin
      term = mcd_pkg::OneQ14 + qc;
    end else begin
      term = mcd_pkg::OneQ14 - qc;
    end
  end

  // Work registers of one pair.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q[0] <= in_i.first_x;
      a_q[1] <= in_i.first_y;
      a_q[2] <= in_i.first_z;
      b_q[0] <= in_i.second_x;
      b_q[1] <= in_i.second_y;
      b_q[2] <= in_i.second_z;
      pair_q <= in_i.pair_present;
      last_q <= in_i.end_of_set;
      n1_q   <= '0;
      n2_q   <= '0;
      dot_q  <= '0;
    end
    if (cmd_i.prod) begin
      n1_q  <= n1_q + 32'(p_aa);
      n2_q  <= n2_q + 32'(p_bb);
      dot_q <= dot_q + 34'(p_ab);
    end
    if (cmd_i.norm) begin
      x_q     <= 64'(n1_q) * 64'(n2_q);
      res_q   <= '0;
      bit_q   <= 64'd1 << 62;
      neg_q   <= dot_q[33];
      mag_q   <= dot_q[33] ? 33'(-dot_q) : 33'(dot_q);
      degen_q <= (n1_q == '0) || (n2_q == '0);
    end
    if (cmd_i.root) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.qinit) begin
      rem_q <= pnum[NW-1:16];
      num_q <= {pnum[15:0], 32'd0};
      den_q <= res_q[31:0];
    end
    if (cmd_i.minit) begin
      rem_q <= '0;
      num_q <= NW'(mnum) << (NW - SumW - 1);
      den_q <= 32'(pcnt_q);
    end
    if (cmd_i.step) begin
      rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
      num_q <= {num_q[NW-2:0], qbit};
    end
  end

  // Set state: running sum, pair count and degenerate flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pcnt_q <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.done) begin
      sum_q  <= '0;
      pcnt_q <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.accum) begin
      sum_q  <= sum_q + SumW'(term);
      pcnt_q <= pcnt_q + CntW'(1);
      flag_q <= flag_q | degen_q;
    end
  end

  // Output register; a beat leaves when the sink does not stall.
  logic [31:0] pcnt_ext;
  assign pcnt_ext = 32'(pcnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      out_q.mean_distance <= (pcnt_q == '0) ? 16'd0 : num_q[15:0];
      out_q.pair_count    <= pcnt_ext[12:0];
      out_q.degenerate    <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Status towards the controller.
  always_comb begin
    sts_o.pair_ok   = in_i.pair_present && (pcnt_q < CntW'(MaxPairs));
    sts_o.last      = cmd_i.load ? in_i.end_of_set : (last_q | ~pair_q & last_q);
    sts_o.zero_norm = (n1_q == '0) || (n2_q == '0);
    sts_o.cnt_zero  = (pcnt_q == '0);
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/mean_cosine_distance_core.sv @@
// ----------------------------------------------------------------------------
// mean_cosine_distance_core
// Accumulates one minus the cosine of the angle between ray pairs and emits
// the rounded mean at the end of each set.
// ----------------------------------------------------------------------------
//  channel  direction  payload      handshake
//  in       sink       in_beat_t    in_valid_i / in_stall_o
//  out      source     out_beat_t   out_valid_o / out_stall_i
//
//  A beat carrying a counted pair passes the accept, product and norm product
//  states, 32 square root steps, a set-up state and 16 quotient steps of the
//  shared restoring divider, then the accumulate state. A pair with a
//  zero-length ray skips root and quotient. An end of set adds a set-up
//  state, the mean division over SumW + 1 quotient bits and the done state,
//  SumW being the sum width (28 at the default limit); an empty set skips the
//  division. A beat with nothing to compute leaves the controller idle.
//  Reset clears the set state and the output valid; no clearing pass.
//  While a result beat is stalled a further result waits in the done state.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_cosine_distance_core #(
  parameter int unsigned MaxPairs = mcd_pkg::MaxPairsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mcd_pkg::in_beat_t   in_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mcd_pkg::out_beat_t  out_o
);

  localparam int unsigned CntW = $clog2(MaxPairs + 1);
  localparam int unsigned SumW = CntW + 15;

  mcd_pkg::cmd_t cmd;
  mcd_pkg::sts_t sts;

  mcd_ctrl #(
    .MeanSteps (SumW + 1)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcd_dpath #(
    .MaxPairs (MaxPairs),
    .CntW     (CntW),
    .SumW     (SumW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A result never averages above one in Q1.14 times two.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.mean_distance <= 16'd32768))
    else $error("mean above 2.0");

  // A nonzero mean needs at least one pair.
  a_mean_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.mean_distance != 16'd0)) |-> (out_o.pair_count != 13'd0))
    else $error("nonzero mean without pairs");

  // The degenerate flag needs at least one pair.
  a_degen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.degenerate) |-> (out_o.pair_count != 13'd0))
    else $error("degenerate flag without pairs");

endmodule

`default_nettype wire

@@ test/mean_cosine_distance_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mean_cosine_distance_core_tb
// Self-checking bench: drives ray pairs with random gaps and output stalls,
// predicts each set's mean cosine distance and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_cosine_distance_core_tb;

  localparam int unsigned MaxPairs = 4096;
  localparam int unsigned RandBeats = 1350;
  localparam longint CycleLimit = 3000000;

  // Predictor of the set accumulator and store of expected result beats.
  class mean_distance_board;
    longint unsigned    term_sum;
    int unsigned        pairs_held;
    bit                 zero_ray_seen;
    mcd_pkg::out_beat_t pending_means[$];
    int unsigned        error_count;
    int unsigned        beats_checked;

    function new();
      term_sum = 0;
      pairs_held = 0;
      zero_ray_seen = 0;
      error_count = 0;
      beats_checked = 0;
    endfunction

    // Integer square root, bit by bit.
    function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // One minus the cosine of one pair, in Q1.14.
    function automatic int unsigned pair_distance(mcd_pkg::in_beat_t b,
                                                  output bit zero_ray);
      longint signed dot;
      longint unsigned n1;
      longint unsigned n2;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      longint signed ax, ay, az, bx, by, bz;
      ax = b.first_x;  ay = b.first_y;  az = b.first_z;
      bx = b.second_x; by = b.second_y; bz = b.second_z;
      dot = ax * bx + ay * by + az * bz;
      n1 = ax * ax + ay * ay + az * az;
      n2 = bx * bx + by * by + bz * bz;
      if (n1 == 0 || n2 == 0) begin
        zero_ray = 1'b1;
        return 16384;
      end
      zero_ray = 1'b0;
      den = root_floor(n1 * n2);
      if (den == 0) den = 1;
      mag = (dot < 0) ? longint'(-dot) : longint'(dot);
      q = ((mag << 14) + den / 2) / den;
      if (q > 16384) q = 16384;
      return (dot < 0) ? int'(16384 + q) : int'(16384 - q);
    endfunction

    // Notes one accepted input beat.
    function void note_input(mcd_pkg::in_beat_t b);
      bit zr;
      mcd_pkg::out_beat_t r;
      if (b.pair_present && pairs_held < MaxPairs) begin
        term_sum += pair_distance(b, zr);
        pairs_held++;
        if (zr) zero_ray_seen = 1'b1;
      end
      if (b.end_of_set) begin
        r.mean_distance = (pairs_held == 0) ? 16'd0 :
                          16'((term_sum + pairs_held / 2) / pairs_held);
        r.pair_count = 13'(pairs_held);
        r.degenerate = zero_ray_seen;
        pending_means = {pending_means, r};
        term_sum = 0;
        pairs_held = 0;
        zero_ray_seen = 0;
      end
    endfunction

    // Checks one accepted result beat against the oldest expectation.
    function void check_result(mcd_pkg::out_beat_t got);
      mcd_pkg::out_beat_t exp_b;
      beats_checked++;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        error_count++;
        return;
      end
      exp_b = pending_means.pop_front();
      if (got.mean_distance !== exp_b.mean_distance) begin
        $display("%0t: mean_distance expected %0d actual %0d", $time,
                 exp_b.mean_distance, got.mean_distance);
        error_count++;
      end
      if (got.pair_count !== exp_b.pair_count) begin
        $display("%0t: pair_count expected %0d actual %0d", $time,
                 exp_b.pair_count, got.pair_count);
        error_count++;
      end
      if (got.degenerate !== exp_b.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time,
                 exp_b.degenerate, got.degenerate);
        error_count++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mcd_pkg::in_beat_t  in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mcd_pkg::out_beat_t out_o;

  mean_distance_board board;
  longint    cycle_count;
  bit        drain_stalls;
  int unsigned beats_sent;

  mean_cosine_distance_core #(.MaxPairs(MaxPairs)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Random component with a bias towards extremes and zero.
  function automatic logic [15:0] pick_component();
    unique case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mcd_pkg::in_beat_t make_pair(bit last);
    mcd_pkg::in_beat_t b;
    b.first_x = pick_component();
    b.first_y = pick_component();
    b.first_z = pick_component();
    b.second_x = pick_component();
    b.second_y = pick_component();
    b.second_z = pick_component();
    // Occasionally a parallel or opposite ray.
    if ($urandom_range(0, 7) == 0) begin
      b.second_x = b.first_x;
      b.second_y = b.first_y;
      b.second_z = b.first_z;
    end else if ($urandom_range(0, 7) == 0) begin
      b.second_x = -b.first_x;
      b.second_y = -b.first_y;
      b.second_z = -b.first_z;
    end
    b.pair_present = 1'b1;
    b.end_of_set = last;
    return b;
  endfunction

  // Sends one beat after a random gap and waits for its acceptance.
  task automatic send_beat(mcd_pkg::in_beat_t b, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(b);
    beats_sent++;
  endtask

  task automatic send_set(int unsigned n, bit empty_tail, bit burst);
    mcd_pkg::in_beat_t b;
    for (int unsigned k = 0; k < n; k++) begin
      b = make_pair(!empty_tail && k == n - 1);
      send_beat(b, burst);
    end
    if (empty_tail || n == 0) begin
      b = make_pair(1'b1);
      b.pair_present = 1'b0;
      send_beat(b, burst);
    end
  endtask

  // Output side: random stalls, result checked on acceptance.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = drain_stalls ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_result(out_o);
    end
  end

  // Cycle watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("mean_cosine_distance_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    mcd_pkg::in_beat_t b;
    board = new();
    in_valid_i = 1'b0;
    in_i = '0;
    drain_stalls = 1'b0;
    beats_sent = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: empty set, extremes, zero-length rays, parallel and opposite.
    send_set(0, 1'b1, 1'b0);
    b = '0; b.pair_present = 1'b0; b.end_of_set = 1'b0;
    send_beat(b, 1'b0);
    b.end_of_set = 1'b1;
    send_beat(b, 1'b0);
    b = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1};
    send_beat(b, 1'b0);
    b = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1};
    send_beat(b, 1'b0);
    b = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0};
    send_beat(b, 1'b0);
    b = '{16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b0};
    send_beat(b, 1'b0);
    b = '{16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 1'b1, 1'b0};
    send_beat(b, 1'b0);
    b = '0; b.end_of_set = 1'b1;
    send_beat(b, 1'b0);
    b = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1};
    send_beat(b, 1'b0);
    b = '{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, 1'b1};
    send_beat(b, 1'b0);
    send_set(3, 1'b0, 1'b1);
    send_set(2, 1'b1, 1'b1);

    // Random sets, mostly small, some back-to-back.
    while (beats_sent < RandBeats) begin
      send_set($urandom_range(1, 12), $urandom_range(0, 3) == 0,
               $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        b = make_pair(1'b0);
        b.pair_present = 1'b0;
        send_beat(b, 1'b0);
      end
    end
    in_valid_i <= 1'b0;
    drain_stalls = 1'b1;

    while (board.pending_means.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d input beats in directed and random sets, checked %0d results.",
             beats_sent, board.beats_checked);
    if (board.error_count == 0) begin
      $display("mean_cosine_distance_core_tb: done, clean");
    end else begin
      $display("mean_cosine_distance_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
